// ===== src/mots_pkg.sv =====
// shared types for the median of two sorted arrays block
// no dependencies
package mots_pkg;
  typedef logic signed [31:0] elem_t;
  typedef logic signed [32:0] dbl_t;
endpackage

// ===== src/mots_ram.sv =====
// element store: one write port, one read port with registered data
// depends on mots_pkg
module mots_ram import mots_pkg::*; #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  elem_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output elem_t            rdata_o
);
  elem_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/median_of_two_sorted_arrays.sv =====
// top level: loads two sorted arrays and reports twice the median of both
// depends on mots_pkg and mots_ram
//
// usage:
// - input channel (in_valid_i / in_ready_o) carries one element per beat;
//   action_i picks the array, last_i closes the data set
// - loading accepts a beat whenever in_ready_o is high; an element for a full array is dropped
// - after the last beat the sequencer reads both stores, one address per store
//   per cycle, with registered read data; after the shape checks it runs halving
//   steps and then merge steps (at most SCAN_THRESHOLD merge steps), done twice,
//   once per middle element (the same element again for an odd total)
// - one result beat (out_valid_o / out_ready_i) per last beat; empty_error_o
//   marks an empty set with median_doubled_o zero
// - in_ready_o is high only while loading; a finished result waits in the
//   output register, loading of the next set goes on meanwhile; if the next
//   result is ready while the receiver still stalls, input stays blocked
// - reset clears fill counts and control; stores need no clearing
module median_of_two_sorted_arrays import mots_pkg::*; #(
  parameter int ARRAY_DEPTH    = 1024,
  parameter int SCAN_THRESHOLD = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  action_i,
  input  elem_t value_i,
  input  logic  last_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output dbl_t  median_doubled_o,
  output logic  empty_error_o
);
  localparam int AW  = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int CW  = $clog2(ARRAY_DEPTH + 1);
  localparam int TW0 = $clog2(2 * ARRAY_DEPTH + 1);
  localparam int TW  = (TW0 > 7) ? TW0 : 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_E1    = 4'd2;
  localparam logic [3:0] S_E2    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_RDW   = 4'd5;
  localparam logic [3:0] S_SINIT = 4'd6;
  localparam logic [3:0] S_SLOOP = 4'd7;
  localparam logic [3:0] S_SCMP  = 4'd8;
  localparam logic [3:0] S_K1    = 4'd9;
  localparam logic [3:0] S_WALK  = 4'd10;
  localparam logic [3:0] S_WCMP  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]    state_q;
  logic [CW-1:0] cnt_a_q, cnt_b_q;
  logic [TW-1:0] m_q, n_q, sm_q, sn_q, k_q, k2_q, oa_q, ob_q, cut_q;
  logic [TW-1:0] i_q, j_q, left_q, idx_q, idx2_q;
  logic          swp_q, sel_q, single_q, pick_q;
  elem_t         v1_q, a0_q, bn1_q;
  dbl_t          res_q, md_q;
  logic          err_q, eo_q, out_valid_q;

  logic          in_acc, we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b;
  elem_t         qa, qb, da, db, v;
  logic          got_v;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign we_a = in_acc && !action_i && (cnt_a_q < CW'(ARRAY_DEPTH));
  assign we_b = in_acc && action_i && (cnt_b_q < CW'(ARRAY_DEPTH));

  mots_ram #(.Depth(ARRAY_DEPTH), .AddrW(AW)) u_ram_a (
    .clk_i, .we_i(we_a), .waddr_i(cnt_a_q[AW-1:0]), .wdata_i(value_i),
    .raddr_i(raddr_a), .rdata_o(qa)
  );
  mots_ram #(.Depth(ARRAY_DEPTH), .AddrW(AW)) u_ram_b (
    .clk_i, .we_i(we_b), .waddr_i(cnt_b_q[AW-1:0]), .wdata_i(value_i),
    .raddr_i(raddr_b), .rdata_o(qb)
  );

  // swapped view for a halving step
  logic          do_sw, swp2, big_k;
  logic [TW-1:0] m2, n2, oa2, ob2, kh, cut2, pa_idx, pb_idx, tot, cm, cn;
  logic          swp_rd;

  assign tot   = m_q + n_q;
  assign cm    = TW'(cnt_a_q);
  assign cn    = TW'(cnt_b_q);
  assign big_k = k_q > TW'(SCAN_THRESHOLD);
  assign do_sw = sm_q > sn_q;
  assign m2    = do_sw ? sn_q : sm_q;
  assign n2    = do_sw ? sm_q : sn_q;
  assign oa2   = do_sw ? ob_q : oa_q;
  assign ob2   = do_sw ? oa_q : ob_q;
  assign swp2  = swp_q ^ do_sw;
  assign kh    = k_q >> 1;
  assign cut2  = (m2 < kh) ? m2 : kh;

  always_comb begin
    pa_idx = oa_q;
    pb_idx = ob_q;
    swp_rd = swp_q;
    if (state_q == S_SLOOP && big_k) begin
      pa_idx = oa2 + cut2 - TW'(1);
      pb_idx = ob2 + k_q - cut2 - TW'(1);
      swp_rd = swp2;
    end else if (state_q == S_WALK) begin
      pa_idx = oa_q + i_q;
      pb_idx = ob_q + j_q;
    end
    raddr_a = swp_rd ? pb_idx[AW-1:0] : pa_idx[AW-1:0];
    raddr_b = swp_rd ? pa_idx[AW-1:0] : pb_idx[AW-1:0];
    case (state_q)
      S_START: begin
        raddr_a = '0;
        raddr_b = AW'(cn - TW'(1));
      end
      S_E1: begin
        raddr_a = AW'(m_q - TW'(1));
        raddr_b = '0;
      end
      S_RD: begin
        raddr_a = idx_q[AW-1:0];
        raddr_b = idx_q[AW-1:0];
      end
      default: ;
    endcase
  end

  assign da = swp_q ? qb : qa;
  assign db = swp_q ? qa : qb;

  always_comb begin
    got_v = 1'b0;
    v     = da;
    case (state_q)
      S_RDW: begin
        got_v = 1'b1;
        v     = sel_q ? qb : qa;
      end
      S_K1: begin
        got_v = 1'b1;
        v     = (da < db) ? da : db;
      end
      S_WCMP: begin
        got_v = (left_q == TW'(1));
        v     = (da < db) ? da : db;
      end
      default: ;
    endcase
  end

  // single array median picks
  logic          sg_sel;
  logic [TW-1:0] sg_len, sg_i1, sg_i2;
  logic          a_ge, b_ge;

  assign a_ge = a0_q >= bn1_q;
  assign b_ge = qb >= qa;

  always_comb begin
    sg_sel = 1'b0;
    sg_len = cm;
    if (state_q == S_START) begin
      if (cn != '0) begin
        sg_sel = 1'b1;
        sg_len = cn;
      end
    end else if (a_ge) begin
      if (m_q > n_q) begin
        sg_len = m_q - n_q;
      end else begin
        sg_sel = 1'b1;
        sg_len = tot;
      end
    end else if (m_q < n_q) begin
      sg_sel = 1'b1;
      sg_len = n_q - m_q;
    end else begin
      sg_len = tot;
    end
    sg_i2 = sg_len >> 1;
    sg_i1 = sg_len[0] ? sg_i2 : sg_i2 - TW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      out_valid_q <= 1'b0;
      pick_q      <= 1'b0;
      single_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (we_a) cnt_a_q <= cnt_a_q + CW'(1);
          if (we_b) cnt_b_q <= cnt_b_q + CW'(1);
          if (in_acc && last_i) state_q <= S_START;
        end
        S_START: begin
          m_q    <= cm;
          n_q    <= cn;
          err_q  <= 1'b0;
          pick_q <= 1'b0;
          if (cm == '0 && cn == '0) begin
            res_q   <= '0;
            err_q   <= 1'b1;
            state_q <= S_FIN;
          end else if (cm == '0 || cn == '0) begin
            single_q <= 1'b1;
            sel_q    <= sg_sel;
            idx_q    <= sg_i1;
            idx2_q   <= sg_i2;
            state_q  <= S_RD;
          end else begin
            state_q <= S_E1;
          end
        end
        S_E1: begin
          a0_q    <= qa;
          bn1_q   <= qb;
          state_q <= S_E2;
        end
        S_E2: begin
          if ((a_ge || b_ge) && m_q == n_q) begin
            res_q   <= a_ge ? dbl_t'(a0_q) + dbl_t'(bn1_q) : dbl_t'(qb) + dbl_t'(qa);
            state_q <= S_FIN;
          end else if (a_ge || b_ge) begin
            single_q <= 1'b1;
            sel_q    <= sg_sel;
            idx_q    <= sg_i1;
            idx2_q   <= sg_i2;
            state_q  <= S_RD;
          end else begin
            single_q <= 1'b0;
            k_q      <= tot[0] ? (tot >> 1) + TW'(1) : (tot >> 1);
            k2_q     <= (tot >> 1) + TW'(1);
            state_q  <= S_SINIT;
          end
        end
        S_RD: state_q <= S_RDW;
        S_SINIT: begin
          sm_q    <= m_q;
          sn_q    <= n_q;
          oa_q    <= '0;
          ob_q    <= '0;
          swp_q   <= 1'b0;
          state_q <= S_SLOOP;
        end
        S_SLOOP: begin
          if (big_k) begin
            sm_q  <= m2;
            sn_q  <= n2;
            oa_q  <= oa2;
            ob_q  <= ob2;
            swp_q <= swp2;
            if (m2 == '0) begin
              sel_q   <= ~swp2;
              idx_q   <= ob2 + k_q - TW'(1);
              state_q <= S_RD;
            end else begin
              cut_q   <= cut2;
              state_q <= S_SCMP;
            end
          end else if (k_q == TW'(1)) begin
            if (sm_q == '0) begin
              sel_q   <= ~swp_q;
              idx_q   <= ob_q;
              state_q <= S_RD;
            end else if (sn_q == '0) begin
              sel_q   <= swp_q;
              idx_q   <= oa_q;
              state_q <= S_RD;
            end else begin
              state_q <= S_K1;
            end
          end else begin
            i_q     <= '0;
            j_q     <= '0;
            left_q  <= k_q;
            state_q <= S_WALK;
          end
        end
        S_SCMP: begin
          if (da < db) begin
            oa_q <= oa_q + cut_q;
            sm_q <= sm_q - cut_q;
            k_q  <= k_q - cut_q;
          end else begin
            ob_q <= ob_q + k_q - cut_q;
            sn_q <= sn_q - (k_q - cut_q);
            k_q  <= cut_q;
          end
          state_q <= S_SLOOP;
        end
        S_WALK: begin
          if (i_q < sm_q && j_q < sn_q) begin
            state_q <= S_WCMP;
          end else if (i_q == sm_q) begin
            sel_q   <= ~swp_q;
            idx_q   <= ob_q + k_q - i_q - TW'(1);
            state_q <= S_RD;
          end else begin
            sel_q   <= swp_q;
            idx_q   <= oa_q + k_q - j_q - TW'(1);
            state_q <= S_RD;
          end
        end
        S_WCMP: begin
          if (da < db) begin
            i_q <= i_q + TW'(1);
          end else begin
            j_q <= j_q + TW'(1);
          end
          left_q  <= left_q - TW'(1);
          state_q <= S_WALK;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            md_q        <= res_q;
            eo_q        <= err_q;
            cnt_a_q     <= '0;
            cnt_b_q     <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (got_v) begin
        if (!pick_q) begin
          v1_q   <= v;
          pick_q <= 1'b1;
          if (single_q) begin
            idx_q   <= idx2_q;
            state_q <= S_RD;
          end else begin
            k_q     <= k2_q;
            state_q <= S_SINIT;
          end
        end else begin
          res_q   <= dbl_t'(v1_q) + dbl_t'(v);
          state_q <= S_FIN;
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = md_q;
  assign empty_error_o    = eo_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(ARRAY_DEPTH)) && (cnt_b_q <= CW'(ARRAY_DEPTH)))
    else $error("fill count beyond depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_error_o) |-> (median_doubled_o == '0))
    else $error("empty set with nonzero median");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!out_valid_q || out_ready_i)) |=>
      (cnt_a_q == '0 && cnt_b_q == '0 && out_valid_q && state_q == S_IDLE))
    else $error("result hand-off did not reset the data set");
endmodule

// ===== sim/tb_median_of_two_sorted_arrays.sv =====
// testbench for median_of_two_sorted_arrays: random and directed data sets,
// predicted medians checked beat by beat in a scoreboard class
// depends on mots_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_median_of_two_sorted_arrays;
  import mots_pkg::*;

  localparam int DEPTH = 1024;
  localparam int THRESH = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    dbl_t med;
    logic empty;
  } median_t;

  int errors = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  class median_board;
    elem_t a_store[DEPTH];
    elem_t b_store[DEPTH];
    int a_len, b_len;
    median_t pending[$];
    int sets, checked;

    function longint kth(int m, int n, int k);
      int pa, pb, tp, tn, cut, i, j, left;
      logic sw;
      pa = 0; pb = 0; sw = 1'b0;
      while (k > THRESH) begin
        if (m > n) begin
          tp = pa; pa = pb; pb = tp; tn = m; m = n; n = tn; sw = !sw;
        end
        if (m == 0) return rd(!sw, pb + k - 1);
        cut = (m < k / 2) ? m : k / 2;
        if (rd(sw, pa + cut - 1) < rd(!sw, pb + k - cut - 1)) begin
          pa += cut; m -= cut; k -= cut;
        end else begin
          pb += k - cut; n -= k - cut; k = cut;
        end
      end
      if (k == 1) begin
        if (m == 0) return rd(!sw, pb);
        if (n == 0) return rd(sw, pa);
        return (rd(sw, pa) < rd(!sw, pb)) ? rd(sw, pa) : rd(!sw, pb);
      end
      i = 0; j = 0; left = k;
      while (i < m && j < n) begin
        if (rd(sw, pa + i) < rd(!sw, pb + j)) begin
          left--;
          if (left == 0) return rd(sw, pa + i);
          i++;
        end else begin
          left--;
          if (left == 0) return rd(!sw, pb + j);
          j++;
        end
      end
      if (i == m) return rd(!sw, pb + k - i - 1);
      return rd(sw, pa + k - j - 1);
    endfunction

    function longint rd(logic second, int idx);
      return second ? longint'(b_store[idx]) : longint'(a_store[idx]);
    endfunction

    function longint single(logic second, int len);
      if (len % 2) return 2 * rd(second, len / 2);
      return rd(second, len / 2 - 1) + rd(second, len / 2);
    endfunction

    function longint doubled(int m, int n);
      int tot;
      tot = m + n;
      if (n == 0) return single(1'b0, m);
      if (m == 0) return single(1'b1, n);
      if (a_store[0] >= b_store[n - 1]) begin
        if (m == n) return longint'(a_store[0]) + longint'(b_store[n - 1]);
        if (m > n) return single(1'b0, m - n);
        return single(1'b1, tot);
      end
      if (b_store[0] >= a_store[m - 1]) begin
        if (m == n) return longint'(b_store[0]) + longint'(a_store[m - 1]);
        if (m < n) return single(1'b1, n - m);
        return single(1'b0, tot);
      end
      if (tot % 2) return 2 * kth(m, n, tot / 2 + 1);
      return kth(m, n, tot / 2) + kth(m, n, tot / 2 + 1);
    endfunction

    function void note_input(logic act, elem_t v, logic lst);
      median_t e;
      if (!act) begin
        if (a_len < DEPTH) a_store[a_len++] = v;
      end else if (b_len < DEPTH) b_store[b_len++] = v;
      if (!lst) return;
      if (a_len == 0 && b_len == 0) begin
        e.med = '0; e.empty = 1'b1;
      end else begin
        e.med = dbl_t'(doubled(a_len, b_len)); e.empty = 1'b0;
      end
      pending.push_back(e);
      sets++;
      a_len = 0; b_len = 0;
    endfunction

    task check_result(dbl_t med, logic empty);
      median_t e;
      checked++;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (med !== e.med)
        report($sformatf("median_doubled got %0d want %0d", med, e.med));
      if (empty !== e.empty)
        report($sformatf("empty_error got %0b want %0b", empty, e.empty));
    endtask
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, action_i = 1'b0, last_i = 1'b0, out_ready_i = 1'b0;
  elem_t value_i = '0;
  logic in_ready_o, out_valid_o, empty_error_o;
  dbl_t median_doubled_o;

  median_board board = new();
  int hold_cycles = 0;
  int idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  median_of_two_sorted_arrays DUT (.*);

  // beats are noted in the board at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_input(action_i, value_i, last_i);
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(median_doubled_o, empty_error_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      w = $urandom_range(0, 10);
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  task automatic send(input logic act, input elem_t v, input logic lst);
    int w;
    w = $urandom_range(0, 10);
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1'b1; action_i <= act; value_i <= v; last_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // random sorted set of the given sizes; both arrays share the value span
  task automatic send_set(input int m, input int n, input int span);
    elem_t a[$], b[$];
    int i, ia, ib;
    elem_t base;
    base = (span < 0) ? elem_t'($urandom) : elem_t'($urandom_range(0, 200)) - 100;
    for (i = 0; i < m; i++) begin
      a.push_back((span < 0) ? elem_t'($urandom) : base + elem_t'($urandom_range(0, span)));
    end
    for (i = 0; i < n; i++) begin
      b.push_back((span < 0) ? elem_t'($urandom) : base + elem_t'($urandom_range(0, span)));
    end
    a.sort(); b.sort();
    ia = 0; ib = 0;
    while (ia + ib < m + n) begin
      if (ib >= n || (ia < m && $urandom_range(0, 1))) begin
        send(1'b0, a[ia], ia + ib == m + n - 1); ia++;
      end else begin
        send(1'b1, b[ib], ia + ib == m + n - 1); ib++;
      end
    end
  endtask

  initial begin
    int items, i, m, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, disjoint and interleaved shapes, ties
    send(1'b0, 32'sh7fffffff, 1'b1);
    send(1'b1, 32'sh80000000, 1'b1);
    send(1'b0, 32'sh80000000, 1'b0); send(1'b1, 32'sh7fffffff, 1'b1);
    send(1'b0, 32'sh7fffffff, 1'b0); send(1'b0, 32'sh7fffffff, 1'b1);
    send(1'b0, 5, 1'b0); send(1'b1, 5, 1'b0); send(1'b0, 5, 1'b0); send(1'b1, 5, 1'b1);
    send(1'b1, 1, 1'b0); send(1'b1, 2, 1'b0); send(1'b0, 3, 1'b0); send(1'b0, 4, 1'b0);
    send(1'b0, 9, 1'b1);
    send(1'b0, 1, 1'b0); send(1'b1, 2, 1'b0); send(1'b0, 3, 1'b0); send(1'b1, 4, 1'b0);
    send(1'b0, 0, 1'b1);
    send(1'b1, 0, 1'b0); send(1'b0, -1, 1'b1);
    drain();
    items = 22;
    // pressure: long receiver hold-off while sets keep arriving
    hold_cycles = 400;
    for (i = 0; i < 6; i++) send_set(2, 3, 50);
    drain();
    items += 30;
    // random sets, mostly small, some past the halving threshold
    while (items < 680) begin
      case ($urandom_range(0, 9))
        0: begin m = $urandom_range(0, 1); n = $urandom_range(0, 1); end
        1, 2: begin m = $urandom_range(10, 40); n = $urandom_range(10, 40); end
        default: begin m = $urandom_range(0, 8); n = $urandom_range(0, 8); end
      endcase
      if (m + n == 0) m = 1;
      send_set(m, n, ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(1, 60));
      items += m + n;
      if ($urandom_range(0, 15) == 0) drain();
    end
    // unsorted noise
    for (i = 0; i < 20; i++) send(1'($urandom_range(0, 1)), elem_t'($urandom), i % 5 == 4);
    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d data sets, %0d result beats checked", board.sets, board.checked);
    if (errors == 0 && board.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/mots_pkg.sv
src/mots_ram.sv
src/median_of_two_sorted_arrays.sv
sim/tb_median_of_two_sorted_arrays.sv
